### src/shge_pkg.sv
// Shared types and codes for the sand hourglass grid engine.
// Used by shge_grid, shge_seq and sand_hourglass_grid_engine; no dependencies.
package shge_pkg;

    // Operation codes carried in the command
    localparam logic [2:0] OP_FILL   = 3'd0;
    localparam logic [2:0] OP_DROP   = 3'd1;
    localparam logic [2:0] OP_SETTLE = 3'd2;
    localparam logic [2:0] OP_FLIP   = 3'd3;
    localparam logic [2:0] OP_MASK   = 3'd4;
    localparam logic [2:0] OP_READ   = 3'd5;

    // Stream widths
    localparam int ROW_OUT_W  = 8;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 24;

    // Per-grid memory control
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } grid_ctl_t;

    // One decoded command
    typedef struct packed {
        logic [2:0] op;
        logic       dir;
        logic       sel;
        logic       mval;
        logic [2:0] row;
    } cmd_t;

    // One result
    typedef struct packed {
        logic                 dropped;
        logic [ROW_OUT_W-1:0] row_b;
        logic [ROW_OUT_W-1:0] row_a;
    } res_t;

endpackage

### src/shge_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module shge_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### src/shge_grid.sv
// One hourglass grid: row RAM plus per-row valid bits giving the reset pattern.
// Depends on shge_pkg and shge_ram.
module shge_grid #(
    parameter int   GRID_ROWS = 8,
    parameter int   GRID_COLS = 8,
    parameter logic RESET_ONE = 1'b0,
    localparam int  AW = $clog2(GRID_ROWS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  shge_pkg::grid_ctl_t  ctl,
    input  logic [AW-1:0]        rd_addr,
    input  logic [AW-1:0]        wr_addr,
    input  logic [GRID_COLS-1:0] wr_data,
    output logic [GRID_COLS-1:0] rd_data
);

    logic [GRID_ROWS-1:0] valid_reg;
    logic                 rd_valid_reg;
    logic [GRID_COLS-1:0] ram_q;

    shge_ram #(
        .WIDTH (GRID_COLS),
        .DEPTH (GRID_ROWS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (ram_q)
    );

    // row valid bits: clear drops the grid back to its reset pattern
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                valid_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    // unwritten rows read as the reset pattern
    assign rd_data = rd_valid_reg ? ram_q : {GRID_COLS{RESET_ONE}};

    // a row is never read and written in the same cycle
    a_no_rw_same_row: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.rd_en && ctl.wr_en) |-> (rd_addr != wr_addr))
        else $error("grid read and write hit the same row");

endmodule

### src/shge_seq.sv
// Operation sequencer: clears, reads or read-modify-writes one or both grid memories per command.
// Depends on shge_pkg.
module shge_seq #(
    parameter int  GRID_ROWS = 8,
    parameter int  GRID_COLS = 8,
    localparam int AW = $clog2(GRID_ROWS),
    localparam int CW = $clog2(GRID_COLS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  shge_pkg::cmd_t       cmd,
    output logic                 idle,
    input  logic                 res_free,
    output logic                 done,
    output shge_pkg::res_t       res,
    output shge_pkg::grid_ctl_t  ctl_a,
    output logic [AW-1:0]        rd_addr_a,
    output logic [AW-1:0]        wr_addr_a,
    output logic [GRID_COLS-1:0] wr_data_a,
    input  logic [GRID_COLS-1:0] rd_data_a,
    output shge_pkg::grid_ctl_t  ctl_b,
    output logic [AW-1:0]        rd_addr_b,
    output logic [AW-1:0]        wr_addr_b,
    output logic [GRID_COLS-1:0] wr_data_b,
    input  logic [GRID_COLS-1:0] rd_data_b
);

    localparam int MASK_LIMIT = GRID_COLS / 2 + GRID_ROWS;
    localparam int C0 = GRID_COLS / 2 - 1;
    localparam int C1 = GRID_COLS / 2;
    localparam logic [GRID_COLS-1:0] PAIR_MASK = GRID_COLS'(3) << C0;
    localparam logic [AW-1:0] LAST_ROW = AW'(GRID_ROWS - 1);

    // state codes
    localparam logic [4:0] ST_IDLE      = 5'd0;
    localparam logic [4:0] ST_FILL      = 5'd1;
    localparam logic [4:0] ST_RD_ROW    = 5'd2;
    localparam logic [4:0] ST_DONE      = 5'd3;
    localparam logic [4:0] ST_DROP_RD   = 5'd4;
    localparam logic [4:0] ST_DROP_WR   = 5'd5;
    localparam logic [4:0] ST_FLIP_RD0  = 5'd6;
    localparam logic [4:0] ST_FLIP_RD1  = 5'd7;
    localparam logic [4:0] ST_FLIP_WR0  = 5'd8;
    localparam logic [4:0] ST_FLIP_WR1  = 5'd9;
    localparam logic [4:0] ST_MASK_RD   = 5'd10;
    localparam logic [4:0] ST_MASK_WR   = 5'd11;
    localparam logic [4:0] ST_SET_INIT  = 5'd12;
    localparam logic [4:0] ST_SET_INIT2 = 5'd13;
    localparam logic [4:0] ST_SET_LOAD  = 5'd14;
    localparam logic [4:0] ST_SET_COL   = 5'd15;
    localparam logic [4:0] ST_SET_WB    = 5'd16;
    localparam logic [4:0] ST_SET_WB0   = 5'd17;

    logic [4:0]           state_reg;
    logic [4:0]           state_next;
    shge_pkg::cmd_t       cmd_reg;
    logic [AW-1:0]        row_reg;
    logic [CW-1:0]        col_reg;
    logic                 gsel_reg;
    logic                 outward_reg;
    logic                 dropped_reg;
    logic [GRID_COLS-1:0] cur_reg;
    logic [GRID_COLS-1:0] below_reg;
    logic [GRID_COLS-1:0] hold_a_reg;
    logic [GRID_COLS-1:0] hold_b_reg;

    logic                 row_ok;
    logic [GRID_COLS-1:0] src_row;
    logic                 drop_hit;
    logic                 tgt;
    logic [GRID_COLS-1:0] tgt_rd;
    logic [GRID_COLS-1:0] mrow;
    logic [GRID_COLS-1:0] mask_wr;
    logic [AW-1:0]        mirror_row;
    logic                 go_left;
    logic                 nc_ok;
    logic [CW-1:0]        nc;
    logic [GRID_COLS-1:0] cur_step;
    logic [GRID_COLS-1:0] below_step;
    logic                 g_rd_en;
    logic                 g_wr_en;
    logic [AW-1:0]        g_rd_addr;
    logic [AW-1:0]        g_wr_addr;
    logic [GRID_COLS-1:0] g_wr_data;

    // corner cells outside the hourglass outline in row y
    function automatic logic [GRID_COLS-1:0] mask_row(input logic [AW-1:0] y);
        logic [GRID_COLS-1:0] m;
        m = '0;
        for (int x = 0; x < GRID_COLS; x++)
        begin
            if ((x + int'(y) >= MASK_LIMIT) || (GRID_COLS - 1 - x + int'(y) >= MASK_LIMIT))
            begin
                m[x] = 1'b1;
            end
        end
        return m;
    endfunction

    // shared decode
    assign row_ok     = int'(cmd_reg.row) < GRID_ROWS;
    assign src_row    = cmd_reg.dir ? rd_data_b : rd_data_a;
    assign drop_hit   = src_row[C0] & src_row[C1];
    assign tgt        = ((state_reg == ST_MASK_RD) || (state_reg == ST_MASK_WR)) ?
                        cmd_reg.sel : gsel_reg;
    assign tgt_rd     = tgt ? rd_data_b : rd_data_a;
    assign mrow       = mask_row(row_reg);
    assign mask_wr    = (tgt_rd & ~mrow) | (cmd_reg.mval ? mrow : '0);
    assign mirror_row = LAST_ROW - row_reg;

    // one settle step on the cell at col_reg
    assign go_left = (col_reg >= CW'(GRID_COLS / 2)) != outward_reg;
    assign nc_ok   = go_left ? (col_reg != '0) : (col_reg != CW'(GRID_COLS - 1));
    assign nc      = nc_ok ? (go_left ? col_reg - 1'b1 : col_reg + 1'b1) : col_reg;

    always_comb
    begin
        cur_step   = cur_reg;
        below_step = below_reg;
        if (cur_reg[col_reg])
        begin
            if (!below_reg[col_reg])
            begin
                cur_step[col_reg]   = 1'b0;
                below_step[col_reg] = 1'b1;
            end
            else if (nc_ok && !below_reg[nc] && !cur_reg[nc])
            begin
                cur_step[col_reg] = 1'b0;
                below_step[nc]    = 1'b1;
            end
        end
    end

    // memory access per state
    always_comb
    begin
        ctl_a     = '0;
        ctl_b     = '0;
        rd_addr_a = '0;
        rd_addr_b = '0;
        wr_addr_a = '0;
        wr_addr_b = '0;
        wr_data_a = '0;
        wr_data_b = '0;
        g_rd_en   = 1'b0;
        g_wr_en   = 1'b0;
        g_rd_addr = '0;
        g_wr_addr = '0;
        g_wr_data = '0;
        unique case (state_reg)
            ST_FILL:
            begin
                ctl_a.clear = 1'b1;
                ctl_b.clear = 1'b1;
            end
            ST_RD_ROW:
            begin
                ctl_a.rd_en = row_ok;
                ctl_b.rd_en = row_ok;
                rd_addr_a   = AW'(cmd_reg.row);
                rd_addr_b   = AW'(cmd_reg.row);
            end
            ST_DROP_RD:
            begin
                ctl_a.rd_en = 1'b1;
                ctl_b.rd_en = 1'b1;
                rd_addr_a   = cmd_reg.dir ? '0 : LAST_ROW;
                rd_addr_b   = cmd_reg.dir ? LAST_ROW : '0;
            end
            ST_DROP_WR:
            begin
                ctl_a.wr_en = drop_hit;
                ctl_b.wr_en = drop_hit;
                wr_addr_a   = cmd_reg.dir ? '0 : LAST_ROW;
                wr_addr_b   = cmd_reg.dir ? LAST_ROW : '0;
                wr_data_a   = cmd_reg.dir ? (rd_data_a | PAIR_MASK) : (rd_data_a & ~PAIR_MASK);
                wr_data_b   = cmd_reg.dir ? (rd_data_b & ~PAIR_MASK) : (rd_data_b | PAIR_MASK);
            end
            ST_FLIP_RD0:
            begin
                ctl_a.rd_en = 1'b1;
                ctl_b.rd_en = 1'b1;
                rd_addr_a   = row_reg;
                rd_addr_b   = row_reg;
            end
            ST_FLIP_RD1:
            begin
                ctl_a.rd_en = 1'b1;
                ctl_b.rd_en = 1'b1;
                rd_addr_a   = mirror_row;
                rd_addr_b   = mirror_row;
            end
            ST_FLIP_WR0:
            begin
                ctl_a.wr_en = 1'b1;
                ctl_b.wr_en = 1'b1;
                wr_addr_a   = row_reg;
                wr_addr_b   = row_reg;
                wr_data_a   = rd_data_a;
                wr_data_b   = rd_data_b;
            end
            ST_FLIP_WR1:
            begin
                ctl_a.wr_en = 1'b1;
                ctl_b.wr_en = 1'b1;
                wr_addr_a   = mirror_row;
                wr_addr_b   = mirror_row;
                wr_data_a   = hold_a_reg;
                wr_data_b   = hold_b_reg;
            end
            ST_MASK_RD:
            begin
                g_rd_en   = 1'b1;
                g_rd_addr = row_reg;
            end
            ST_MASK_WR:
            begin
                g_wr_en   = 1'b1;
                g_wr_addr = row_reg;
                g_wr_data = mask_wr;
            end
            ST_SET_INIT:
            begin
                g_rd_en   = 1'b1;
                g_rd_addr = LAST_ROW;
            end
            ST_SET_INIT2:
            begin
                g_rd_en   = 1'b1;
                g_rd_addr = row_reg;
            end
            ST_SET_WB:
            begin
                g_wr_en   = 1'b1;
                g_wr_addr = row_reg + 1'b1;
                g_wr_data = below_reg;
                g_rd_en   = (row_reg != '0);
                g_rd_addr = row_reg - 1'b1;
            end
            ST_SET_WB0:
            begin
                g_wr_en   = 1'b1;
                g_wr_addr = '0;
                g_wr_data = cur_reg;
            end
            default:
            begin
            end
        endcase

        // single-grid accesses go to the target grid
        if (g_rd_en || g_wr_en)
        begin
            if (tgt)
            begin
                ctl_b.rd_en = g_rd_en;
                ctl_b.wr_en = g_wr_en;
                rd_addr_b   = g_rd_addr;
                wr_addr_b   = g_wr_addr;
                wr_data_b   = g_wr_data;
            end
            else
            begin
                ctl_a.rd_en = g_rd_en;
                ctl_a.wr_en = g_wr_en;
                rd_addr_a   = g_rd_addr;
                wr_addr_a   = g_wr_addr;
                wr_data_a   = g_wr_data;
            end
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd.op)
                        shge_pkg::OP_FILL:   state_next = ST_FILL;
                        shge_pkg::OP_DROP:   state_next = ST_DROP_RD;
                        shge_pkg::OP_SETTLE: state_next = ST_SET_INIT;
                        shge_pkg::OP_FLIP:   state_next = ST_FLIP_RD0;
                        shge_pkg::OP_MASK:   state_next = ST_MASK_RD;
                        default:             state_next = ST_RD_ROW;
                    endcase
                end
            end
            ST_FILL:      state_next = ST_RD_ROW;
            ST_RD_ROW:    state_next = ST_DONE;
            ST_DONE:      state_next = res_free ? ST_IDLE : ST_DONE;
            ST_DROP_RD:   state_next = ST_DROP_WR;
            ST_DROP_WR:   state_next = ST_RD_ROW;
            ST_FLIP_RD0:  state_next = ST_FLIP_RD1;
            ST_FLIP_RD1:  state_next = ST_FLIP_WR0;
            ST_FLIP_WR0:  state_next = ST_FLIP_WR1;
            ST_FLIP_WR1:
            begin
                state_next = (row_reg == AW'(GRID_ROWS / 2 - 1)) ? ST_RD_ROW : ST_FLIP_RD0;
            end
            ST_MASK_RD:   state_next = ST_MASK_WR;
            ST_MASK_WR:   state_next = (row_reg == LAST_ROW) ? ST_RD_ROW : ST_MASK_RD;
            ST_SET_INIT:  state_next = ST_SET_INIT2;
            ST_SET_INIT2: state_next = ST_SET_LOAD;
            ST_SET_LOAD:  state_next = ST_SET_COL;
            ST_SET_COL:
            begin
                state_next = (col_reg == CW'(GRID_COLS - 1)) ? ST_SET_WB : ST_SET_COL;
            end
            ST_SET_WB:    state_next = (row_reg == '0) ? ST_SET_WB0 : ST_SET_LOAD;
            ST_SET_WB0:   state_next = outward_reg ? ST_RD_ROW : ST_SET_INIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_reg     <= cmd;
                    dropped_reg <= 1'b0;
                    row_reg     <= '0;
                    gsel_reg    <= cmd.dir;
                    outward_reg <= 1'b0;
                end
            end
            ST_DROP_WR:
            begin
                dropped_reg <= drop_hit;
            end
            ST_FLIP_RD1:
            begin
                hold_a_reg <= rd_data_a;
                hold_b_reg <= rd_data_b;
            end
            ST_FLIP_WR1, ST_MASK_WR:
            begin
                row_reg <= row_reg + 1'b1;
            end
            ST_SET_INIT:
            begin
                row_reg <= AW'(GRID_ROWS - 2);
            end
            ST_SET_INIT2:
            begin
                below_reg <= tgt_rd;
            end
            ST_SET_LOAD:
            begin
                cur_reg <= tgt_rd;
                col_reg <= '0;
            end
            ST_SET_COL:
            begin
                cur_reg   <= cur_step;
                below_reg <= below_step;
                col_reg   <= col_reg + 1'b1;
            end
            ST_SET_WB:
            begin
                if (row_reg != '0)
                begin
                    below_reg <= cur_reg;
                    row_reg   <= row_reg - 1'b1;
                end
            end
            ST_SET_WB0:
            begin
                if (!outward_reg)
                begin
                    gsel_reg    <= ~gsel_reg;
                    outward_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // result
    assign idle        = (state_reg == ST_IDLE);
    assign done        = (state_reg == ST_DONE) && res_free;
    assign res.row_a   = row_ok ? shge_pkg::ROW_OUT_W'(rd_data_a) : '0;
    assign res.row_b   = row_ok ? shge_pkg::ROW_OUT_W'(rd_data_b) : '0;
    assign res.dropped = dropped_reg;

    a_drop_flag_only_on_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res.dropped) |-> (cmd_reg.op == shge_pkg::OP_DROP))
        else $error("grain_dropped set for an operation other than drop");

    a_no_clear_during_write: assert property (@(posedge clk) disable iff (!rst_n)
        !((ctl_a.clear || ctl_b.clear) && (ctl_a.wr_en || ctl_b.wr_en)))
        else $error("grid clear overlaps a row write");

    a_settle_keeps_grains: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SET_COL) |=>
        ($countones(cur_reg) + $countones(below_reg)) ==
        ($past($countones(cur_reg)) + $past($countones(below_reg))))
        else $error("settle step created or lost a grain");

endmodule

### src/sand_hourglass_grid_engine.sv
// Throughput: one transaction at a time; the next is taken once the result sits in the
//   output register. The settle pass steps one cell per cycle through each grid's row RAM.
// Reset (rst_n, async low): grid A reads all ones, grid B all zeros via per-row valid bits;
//   no clearing pass, the block is ready right after reset.
module sand_hourglass_grid_engine #(
    parameter int GRID_ROWS = 8,
    parameter int GRID_COLS = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // operation[2:0], direction[3], grid_select[4], mask_value[5], row_index[8:6]
    input  logic [shge_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // row_bits_a[7:0], row_bits_b[15:8], grain_dropped[16]
    output logic [shge_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    localparam int AW = $clog2(GRID_ROWS);

    shge_pkg::cmd_t       cmd;
    shge_pkg::res_t       res;
    shge_pkg::grid_ctl_t  ctl_a;
    shge_pkg::grid_ctl_t  ctl_b;
    logic [AW-1:0]        rd_addr_a;
    logic [AW-1:0]        wr_addr_a;
    logic [AW-1:0]        rd_addr_b;
    logic [AW-1:0]        wr_addr_b;
    logic [GRID_COLS-1:0] wr_data_a;
    logic [GRID_COLS-1:0] wr_data_b;
    logic [GRID_COLS-1:0] rd_data_a;
    logic [GRID_COLS-1:0] rd_data_b;
    logic                 idle;
    logic                 start;
    logic                 done;
    logic                 res_free;
    logic                 m_valid_reg;
    logic [shge_pkg::M_TDATA_W-1:0] m_data_reg;

    // input unpack
    assign cmd.op   = s_axis_tdata[2:0];
    assign cmd.dir  = s_axis_tdata[3];
    assign cmd.sel  = s_axis_tdata[4];
    assign cmd.mval = s_axis_tdata[5];
    assign cmd.row  = s_axis_tdata[8:6];

    assign s_axis_tready = idle;
    assign start         = s_axis_tvalid && idle;

    shge_grid #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RESET_ONE (1'b1)
    ) u_grid_a (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_a),
        .rd_addr (rd_addr_a),
        .wr_addr (wr_addr_a),
        .wr_data (wr_data_a),
        .rd_data (rd_data_a)
    );

    shge_grid #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS),
        .RESET_ONE (1'b0)
    ) u_grid_b (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl_b),
        .rd_addr (rd_addr_b),
        .wr_addr (wr_addr_b),
        .wr_data (wr_data_b),
        .rd_data (rd_data_b)
    );

    shge_seq #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .cmd       (cmd),
        .idle      (idle),
        .res_free  (res_free),
        .done      (done),
        .res       (res),
        .ctl_a     (ctl_a),
        .rd_addr_a (rd_addr_a),
        .wr_addr_a (wr_addr_a),
        .wr_data_a (wr_data_a),
        .rd_data_a (rd_data_a),
        .ctl_b     (ctl_b),
        .rd_addr_b (rd_addr_b),
        .wr_addr_b (wr_addr_b),
        .wr_data_b (wr_data_b),
        .rd_data_b (rd_data_b)
    );

    // output register
    assign res_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            m_data_reg <= shge_pkg::M_TDATA_W'(res);
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    // one command in flight: an accepted transaction closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while a command is in flight");

endmodule

### verif/sand_hourglass_grid_engine_tb.sv
// Self-checking testbench for sand_hourglass_grid_engine: random and directed commands on
// the input stream, every returned row checked against a bit-accurate grid predictor.
// Depends on shge_pkg and the engine RTL only.
`timescale 1ns / 1ps

// Tracks both hourglass grids and queues the row each accepted command should return
class hourglass_model #(int ROWS = 8, int COLS = 8);

    localparam int MAX_PRINTED = 40;

    bit [31:0]      grid [2][ROWS];    // index 0 grid A, 1 grid B
    shge_pkg::res_t expected_rows [$];
    int             mismatches;
    int             rows_checked;
    int             drops_seen;

    function new();
        fill_grids();
        mismatches   = 0;
        rows_checked = 0;
        drops_seen   = 0;
    endfunction

    function void fill_grids();
        for (int r = 0; r < ROWS; r++)
        begin
            grid[0][r] = (COLS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COLS) - 1);
            grid[1][r] = '0;
        end
    endfunction

    // Moves the two centre grains of the source bottom row to the sink top row
    function bit drop_grains(int src, int dst);
        int c0;
        int c1;
        c0 = COLS / 2 - 1;
        c1 = COLS / 2;
        if (grid[src][ROWS-1][c0] && grid[src][ROWS-1][c1])
        begin
            grid[src][ROWS-1][c0] = 1'b0;
            grid[src][ROWS-1][c1] = 1'b0;
            grid[dst][0][c0]      = 1'b1;
            grid[dst][0][c1]      = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // One in-place falling pass, bottom-up, left to right
    function void settle_grid(int g, bit outward);
        int  nc;
        bit  right_half;
        for (int row = ROWS - 2; row >= 0; row--)
        begin
            for (int col = 0; col < COLS; col++)
            begin
                if (!grid[g][row][col])
                    continue;
                if (!grid[g][row+1][col])
                begin
                    grid[g][row][col]   = 1'b0;
                    grid[g][row+1][col] = 1'b1;
                    continue;
                end
                right_half = (col >= COLS / 2);
                nc = (right_half != outward) ? col - 1 : col + 1;
                // neighbor past either edge is blocked
                if (nc < 0 || nc >= COLS)
                    continue;
                if (!grid[g][row+1][nc] && !grid[g][row][nc])
                begin
                    grid[g][row][col]  = 1'b0;
                    grid[g][row+1][nc] = 1'b1;
                end
            end
        end
    endfunction

    function void flip_grid(int g);
        bit [31:0] tmp;
        for (int i = 0; i < ROWS / 2; i++)
        begin
            tmp              = grid[g][i];
            grid[g][i]        = grid[g][ROWS-1-i];
            grid[g][ROWS-1-i] = tmp;
        end
    endfunction

    // Corner cells outside the hourglass outline
    function void mask_corners(int g, bit value);
        for (int y = 0; y < ROWS; y++)
            for (int x = 0; x < COLS; x++)
                if (x + y >= COLS / 2 + ROWS || (COLS - 1 - x) + y >= COLS / 2 + ROWS)
                    grid[g][y][x] = value;
    endfunction

    // Applies one accepted command and queues the row it should return
    function void apply_command(logic [shge_pkg::S_TDATA_W-1:0] tdata);
        logic [2:0]     op;
        int             src;
        int             dst;
        int             row;
        shge_pkg::res_t want;
        op   = tdata[2:0];
        src  = tdata[3] ? 1 : 0;
        dst  = 1 - src;
        row  = tdata[8:6];
        want = '0;
        case (op)
            shge_pkg::OP_FILL:   fill_grids();
            shge_pkg::OP_DROP:   want.dropped = drop_grains(src, dst);
            shge_pkg::OP_SETTLE:
            begin
                settle_grid(src, 1'b0);
                settle_grid(dst, 1'b1);
            end
            shge_pkg::OP_FLIP:
            begin
                flip_grid(0);
                flip_grid(1);
            end
            shge_pkg::OP_MASK:   mask_corners(tdata[4] ? 1 : 0, tdata[5]);
            default:   ;
        endcase
        if (row < ROWS)
        begin
            want.row_a = grid[0][row][7:0];
            want.row_b = grid[1][row][7:0];
        end
        expected_rows.push_back(want);
    endfunction

    task report_mismatch(string what);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] MISMATCH: %s", $time, what);
        else if (mismatches == MAX_PRINTED)
            $display("[%0t] further mismatches counted but not printed", $time);
        mismatches++;
    endtask

    // Compares one returned row transaction with the oldest expectation
    task check_row(logic [shge_pkg::M_TDATA_W-1:0] tdata);
        shge_pkg::res_t want;
        rows_checked++;
        if (expected_rows.size() == 0)
        begin
            report_mismatch($sformatf("unexpected result tdata=%06h", tdata));
            return;
        end
        want = expected_rows.pop_front();
        if (want.dropped)
            drops_seen++;
        if (tdata[7:0] !== want.row_a)
            report_mismatch($sformatf("row_bits_a got %02h want %02h", tdata[7:0], want.row_a));
        if (tdata[15:8] !== want.row_b)
            report_mismatch($sformatf("row_bits_b got %02h want %02h", tdata[15:8], want.row_b));
        if (tdata[16] !== want.dropped)
            report_mismatch($sformatf("grain_dropped got %b want %b", tdata[16], want.dropped));
    endtask

endclass

module sand_hourglass_grid_engine_tb;

    localparam int GRID_ROWS    = 8;
    localparam int GRID_COLS    = 8;
    localparam int RANDOM_ITEMS = 1650;
    localparam int SETTLE_CYCLES = 160;
    localparam int CYCLE_LIMIT  = 1_500_000;

    // Codes the block treats as a plain row read
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    logic                           clk;
    logic                           rst_n;
    logic                           s_axis_tvalid;
    logic                           s_axis_tready;
    // operation[2:0], direction[3], grid_select[4], mask_value[5], row_index[8:6]
    logic [shge_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready;
    // row_bits_a[7:0], row_bits_b[15:8], grain_dropped[16]
    logic [shge_pkg::M_TDATA_W-1:0] m_axis_tdata;

    hourglass_model #(GRID_ROWS, GRID_COLS) model;

    int cycle_count = 0;
    int items_sent  = 0;
    int op_seen [8];
    bit steady      = 1'b0;    // no idling on either side while set

    sand_hourglass_grid_engine #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // Watchdog
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d rows still expected", cycle_count,
                 model.expected_rows.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // Result monitor
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            model.check_row(m_axis_tdata);

    // Result-side backpressure: mostly ready, short stalls, a few long ones
    initial
    begin
        int stall_left;
        int r;
        stall_left    = 0;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (steady)
            begin
                m_axis_tready <= 1'b1;
                stall_left = 0;
            end
            else if (stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    m_axis_tready <= 1'b1;
                else if (r < 94)
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(0, 2);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    stall_left = $urandom_range(8, 30);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Sends one command transaction, with an optional idle gap in front
    task automatic drive_command(input logic [2:0] op, input bit dir, input bit sel,
                                 input bit mval, input logic [2:0] row);
        int gap;
        gap = steady ? 0 : pick_gap();
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, row, mval, sel, dir, op};
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        model.apply_command(s_axis_tdata);
        op_seen[op]++;
        items_sent++;
    endtask

    // Holds the sender off until every outstanding row has come back
    task automatic drain_rows();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (model.expected_rows.size() != 0)
            @(posedge clk);
    endtask

    task automatic random_command(input bit dir);
        drive_command(3'($urandom_range(0, 7)), dir, 1'($urandom), 1'($urandom),
                      3'($urandom_range(0, 7)));
    endtask

    // Stimulus
    initial
    begin
        bit dir;
        int steps;
        int r;
        model         = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        foreach (op_seen[i])
            op_seen[i] = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset contents, spare codes, drops, edge-blocked slides, masks, flip
        drive_command(shge_pkg::OP_READ,   1'b0, 1'b0, 1'b0, 3'd0);
        drive_command(shge_pkg::OP_READ,   1'b1, 1'b1, 1'b1, 3'd7);
        drive_command(OP_SPARE6,           1'b0, 1'b1, 1'b0, 3'd3);
        drive_command(OP_SPARE7,           1'b1, 1'b0, 1'b1, 3'd5);
        drive_command(shge_pkg::OP_DROP,   1'b0, 1'b0, 1'b0, 3'd0);
        drive_command(shge_pkg::OP_DROP,   1'b0, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_SETTLE, 1'b0, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_SETTLE, 1'b0, 1'b0, 1'b0, 3'd1);
        drive_command(shge_pkg::OP_DROP,   1'b0, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_DROP,   1'b1, 1'b0, 1'b0, 3'd0);
        drive_command(shge_pkg::OP_FLIP,   1'b0, 1'b0, 1'b0, 3'd0);
        drive_command(shge_pkg::OP_SETTLE, 1'b1, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_MASK,   1'b0, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_MASK,   1'b0, 1'b1, 1'b1, 3'd7);
        drive_command(shge_pkg::OP_MASK,   1'b1, 1'b1, 1'b0, 3'd6);
        drive_command(shge_pkg::OP_MASK,   1'b1, 1'b0, 1'b1, 3'd5);
        drive_command(shge_pkg::OP_FILL,   1'b1, 1'b0, 1'b0, 3'd4);
        // sink grid corners full: outer columns try to slide past the edge
        drive_command(shge_pkg::OP_MASK,   1'b0, 1'b1, 1'b1, 3'd6);
        drive_command(shge_pkg::OP_SETTLE, 1'b0, 1'b0, 1'b0, 3'd7);
        drive_command(shge_pkg::OP_SETTLE, 1'b0, 1'b0, 1'b0, 3'd6);
        drive_command(shge_pkg::OP_SETTLE, 1'b1, 1'b0, 1'b0, 3'd5);
        drive_command(shge_pkg::OP_FILL,   1'b0, 1'b1, 1'b1, 3'd2);
        drive_rows_back:
        begin
            drain_rows();
        end

        // Random: hourglass runs of drops and settles, with flips, masks and noise
        while (items_sent < RANDOM_ITEMS + 22)
        begin
            steady = ($urandom_range(0, 4) == 0);
            dir    = 1'($urandom);
            if ($urandom_range(0, 3) != 0)
                drive_command(shge_pkg::OP_FILL, dir, 1'($urandom), 1'($urandom),
                              3'($urandom_range(0, 7)));
            steps = $urandom_range(20, 80);
            for (int k = 0; k < steps; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 38)
                    drive_command(shge_pkg::OP_DROP, dir, 1'($urandom), 1'($urandom),
                                  3'($urandom_range(0, 7)));
                else if (r < 72)
                    drive_command(shge_pkg::OP_SETTLE, dir, 1'($urandom), 1'($urandom),
                                  3'($urandom_range(0, 7)));
                else if (r < 78)
                begin
                    // turning the glass over swaps the flow
                    drive_command(shge_pkg::OP_FLIP, dir, 1'($urandom), 1'($urandom),
                                  3'($urandom_range(0, 7)));
                    dir = ~dir;
                end
                else if (r < 84)
                    drive_command(shge_pkg::OP_MASK, dir, 1'($urandom), 1'($urandom),
                                  3'($urandom_range(0, 7)));
                else if (r < 90)
                    drive_command(shge_pkg::OP_READ, dir, 1'($urandom), 1'($urandom),
                                  3'($urandom_range(0, 7)));
                else
                    random_command(1'($urandom));
            end
            if ($urandom_range(0, 2) == 0)
                drain_rows();
        end

        // Wind down
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        steady = 1'b0;
        while (model.expected_rows.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (model.expected_rows.size() != 0)
            model.report_mismatch($sformatf("%0d rows never returned",
                                            model.expected_rows.size()));
        $display("Sent %0d commands: fill %0d, drop %0d, settle %0d, flip %0d, mask %0d,",
                 items_sent, op_seen[shge_pkg::OP_FILL], op_seen[shge_pkg::OP_DROP],
                 op_seen[shge_pkg::OP_SETTLE], op_seen[shge_pkg::OP_FLIP],
                 op_seen[shge_pkg::OP_MASK]);
        $display("  read %0d, spare codes %0d; %0d rows checked, %0d grain drops, %0d errors",
                 op_seen[shge_pkg::OP_READ], op_seen[OP_SPARE6] + op_seen[OP_SPARE7],
                 model.rows_checked, model.drops_seen, model.mismatches);
        if (model.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### sim.f
src/shge_pkg.sv
src/shge_ram.sv
src/shge_grid.sv
src/shge_seq.sv
src/sand_hourglass_grid_engine.sv
verif/sand_hourglass_grid_engine_tb.sv
